### sv/ultrasonic_obstacle_avoider_assert.svh
// Assertion macros for the checker file of the obstacle avoider.
// No dependencies; included by bare file name.
`ifndef ULTRASONIC_OBSTACLE_AVOIDER_ASSERT_SVH
`define ULTRASONIC_OBSTACLE_AVOIDER_ASSERT_SVH

// same-cycle implication
`define UOA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UOA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/uoa_pkg.sv
// Shared types and constants for the ultrasonic obstacle avoider.
// No dependencies.
package uoa_pkg;

    localparam int SENSOR_COUNT = 4;
    localparam int DIST_W       = 7;
    localparam int TICK_W       = 15;

    // configuration register indexes
    localparam logic [2:0] CFG_CLEARANCE     = 3'd0;
    localparam logic [2:0] CFG_MIN_DISTANCE  = 3'd1;
    localparam logic [2:0] CFG_MAX_DISTANCE  = 3'd2;
    localparam logic [2:0] CFG_ECHO_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_SETTLE_TICKS  = 3'd4;
    localparam logic [2:0] CFG_READING_GAP   = 3'd5;
    localparam logic [2:0] CFG_TRIGGER_WIDTH = 3'd6;

    typedef struct packed {
        logic [6:0]  clearance;
        logic [6:0]  min_distance;
        logic [6:0]  max_distance;
        logic [14:0] echo_timeout;
        logic [9:0]  settle_ticks;
        logic [12:0] reading_gap;
        logic [5:0]  trigger_width;
    } t_cfg;

    typedef logic [SENSOR_COUNT-1:0][DIST_W-1:0] t_dist_arr;

    // per-tick status from the sequencer
    typedef struct packed {
        logic      trigger;
        logic      round_done;
        t_dist_arr dist_cm;
    } t_seq_out;

    typedef enum logic [1:0] {
        MOTOR_FORWARD = 2'd0,
        MOTOR_LEFT    = 2'd1,
        MOTOR_RIGHT   = 2'd2
    } t_motor;

    typedef enum logic [2:0] {
        SIT_SURROUNDED  = 3'd0,
        SIT_FRONT_LEFT  = 3'd1,
        SIT_FRONT_RIGHT = 3'd2,
        SIT_LEFT        = 3'd3,
        SIT_RIGHT       = 3'd4,
        SIT_FRONT       = 3'd5,
        SIT_BACK        = 3'd6,
        SIT_CLEAR       = 3'd7
    } t_situation;

endpackage

### sv/uoa_cfg_regs.sv
// Configuration register file of the obstacle avoider.
// Depends on uoa_pkg.
module uoa_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_index,
    input  logic [14:0]   i_cfg_data,
    output uoa_pkg::t_cfg o_cfg
);

    uoa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clearance     <= 7'd30;
            r_cfg.min_distance  <= 7'd2;
            r_cfg.max_distance  <= 7'd100;
            r_cfg.echo_timeout  <= 15'd30000;
            r_cfg.settle_ticks  <= 10'd200;
            r_cfg.reading_gap   <= 13'd5000;
            r_cfg.trigger_width <= 6'd10;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                uoa_pkg::CFG_CLEARANCE:     r_cfg.clearance     <= i_cfg_data[6:0];
                uoa_pkg::CFG_MIN_DISTANCE:  r_cfg.min_distance  <= i_cfg_data[6:0];
                uoa_pkg::CFG_MAX_DISTANCE:  r_cfg.max_distance  <= i_cfg_data[6:0];
                uoa_pkg::CFG_ECHO_TIMEOUT:  r_cfg.echo_timeout  <= i_cfg_data;
                uoa_pkg::CFG_SETTLE_TICKS:  r_cfg.settle_ticks  <= i_cfg_data[9:0];
                uoa_pkg::CFG_READING_GAP:   r_cfg.reading_gap   <= i_cfg_data[12:0];
                uoa_pkg::CFG_TRIGGER_WIDTH: r_cfg.trigger_width <= i_cfg_data[5:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/uoa_seq.sv
// Ranging sequencer: trigger timing, echo wait and width, cm conversion,
// per-sensor averaging and the distance store. Depends on uoa_pkg.
module uoa_seq #(
    parameter int READINGS_PER_SENSOR = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [3:0]        i_echo_levels,
    input  uoa_pkg::t_cfg     i_cfg,
    output uoa_pkg::t_seq_out o_status
);

    localparam int IDX_W     = $clog2(READINGS_PER_SENSOR + 1);
    localparam int SUM_W     = $clog2(READINGS_PER_SENSOR * 127 + 1);
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + READINGS_PER_SENSOR - 1) / READINGS_PER_SENSOR);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READINGS_PER_SENSOR);
    localparam logic [15:0] PRE_TICKS = 16'd2;

    typedef enum logic [5:0] {
        PH_PRE     = 6'b000001,
        PH_HIGH    = 6'b000010,
        PH_SETTLE  = 6'b000100,
        PH_WAIT    = 6'b001000,
        PH_MEASURE = 6'b010000,
        PH_GAP     = 6'b100000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [14:0]           r_cnt, n_cnt;
    logic [1:0]            r_sensor, n_sensor;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [SUM_W-1:0]      r_sum, n_sum;
    uoa_pkg::t_dist_arr    r_store, n_store;
    // running width in cm: cm = floor(17*w/1000), rem = 17*w mod 1000
    logic [9:0]            r_cm, n_cm;
    logic [9:0]            r_rem, n_rem;

    logic [15:0]           cnt_inc;
    logic [9:0]            rem_add;
    logic [9:0]            cm_step, rem_step;
    logic                  echo;
    logic                  trig;
    logic                  round_done;
    logic                  do_finish;
    logic                  do_end;
    logic [9:0]            raw_cm;
    logic                  map_cm;
    logic [6:0]            fin_cm;
    logic [PROD_W-1:0]     avg_prod;

    assign cnt_inc = {1'b0, r_cnt} + 16'd1;
    assign rem_add = r_rem + 10'd17;
    assign echo    = i_echo_levels[r_sensor];

    always_comb begin
        if (rem_add >= 10'd1000) begin
            rem_step = rem_add - 10'd1000;
            cm_step  = r_cm + 10'd1;
        end else begin
            rem_step = rem_add;
            cm_step  = r_cm;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_sensor   = r_sensor;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_store    = r_store;
        n_cm       = r_cm;
        n_rem      = r_rem;
        trig       = 1'b0;
        round_done = 1'b0;
        do_finish  = 1'b0;
        do_end     = 1'b0;
        raw_cm     = 10'd0;
        map_cm     = 1'b0;
        fin_cm     = 7'd0;
        avg_prod   = '0;

        case (r_phase)
            PH_PRE: begin
                n_cnt = cnt_inc[14:0];
                if (cnt_inc >= PRE_TICKS) begin
                    n_phase = PH_HIGH;
                    n_cnt   = 15'd0;
                end
            end
            PH_HIGH: begin
                trig  = 1'b1;
                n_cnt = cnt_inc[14:0];
                if (cnt_inc >= {10'd0, i_cfg.trigger_width}) begin
                    n_cnt   = 15'd0;
                    n_phase = (i_cfg.settle_ticks == 10'd0) ? PH_WAIT : PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                n_cnt = cnt_inc[14:0];
                if (cnt_inc >= {6'd0, i_cfg.settle_ticks}) begin
                    n_cnt   = 15'd0;
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    // first high tick is width 1
                    n_cnt = 15'd1;
                    n_cm  = 10'd0;
                    n_rem = 10'd17;
                    if (i_cfg.echo_timeout <= 15'd1) begin
                        do_finish = 1'b1;
                        map_cm    = 1'b1;
                        raw_cm    = 10'd0;
                    end else begin
                        n_phase = PH_MEASURE;
                    end
                end else begin
                    n_cnt = cnt_inc[14:0];
                    if (cnt_inc >= {1'b0, i_cfg.echo_timeout}) begin
                        do_finish = 1'b1;  // no echo: reading is max distance
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    n_cnt = cnt_inc[14:0];
                    n_cm  = cm_step;
                    n_rem = rem_step;
                    if (cnt_inc >= {1'b0, i_cfg.echo_timeout}) begin
                        do_finish = 1'b1;
                        map_cm    = 1'b1;
                        raw_cm    = cm_step;
                    end
                end else begin
                    do_finish = 1'b1;
                    map_cm    = 1'b1;
                    raw_cm    = r_cm;
                end
            end
            PH_GAP: begin
                n_cnt = cnt_inc[14:0];
                if (cnt_inc >= {3'd0, i_cfg.reading_gap}) begin
                    do_end = 1'b1;
                end
            end
            default: begin
                n_phase = PH_PRE;
                n_cnt   = 15'd0;
            end
        endcase

        if (do_finish) begin
            if (map_cm && (raw_cm >= {3'd0, i_cfg.min_distance})
                       && (raw_cm <= {3'd0, i_cfg.max_distance})) begin
                fin_cm = raw_cm[6:0];
            end else begin
                fin_cm = i_cfg.max_distance;
            end
            n_sum = r_sum + SUM_W'(fin_cm);
            n_cnt = 15'd0;
            if (i_cfg.reading_gap == 13'd0) begin
                do_end = 1'b1;
            end else begin
                n_phase = PH_GAP;
            end
        end

        if (do_end) begin
            n_idx = r_idx + IDX_W'(1);
            if (n_idx >= LAST_IDX) begin
                // truncated average by reciprocal multiply
                avg_prod          = PROD_W'(n_sum) * PROD_W'(RECIP);
                n_store[r_sensor] = avg_prod[DIV_SHIFT +: 7];
                n_sum             = '0;
                n_idx             = '0;
                n_sensor          = r_sensor + 2'd1;
                round_done        = (r_sensor == 2'd3);
            end
            n_phase = PH_PRE;
            n_cnt   = 15'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PRE;
            r_cnt    <= 15'd0;
            r_sensor <= 2'd0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_store  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_sensor <= n_sensor;
            r_idx    <= n_idx;
            r_sum    <= n_sum;
            r_store  <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_cm  <= n_cm;
            r_rem <= n_rem;
        end
    end

    assign o_status.trigger    = trig;
    assign o_status.round_done = round_done;
    assign o_status.dist_cm    = n_store;

endmodule

### sv/uoa_decide.sv
// Prioritized drive decision from the four stored distances.
// Depends on uoa_pkg.
module uoa_decide (
    input  logic                i_valid,
    input  uoa_pkg::t_dist_arr  i_dist,
    input  logic [6:0]          i_clearance,
    output uoa_pkg::t_motor     o_motor,
    output uoa_pkg::t_situation o_situation
);

    logic f, l, r, b;

    assign f = i_dist[0] < i_clearance;
    assign l = i_dist[1] < i_clearance;
    assign r = i_dist[2] < i_clearance;
    assign b = i_dist[3] < i_clearance;

    always_comb begin
        o_motor     = uoa_pkg::MOTOR_FORWARD;
        o_situation = uoa_pkg::SIT_SURROUNDED;
        if (i_valid) begin
            if (f && l && r && b) begin
                o_motor     = uoa_pkg::MOTOR_RIGHT;
                o_situation = uoa_pkg::SIT_SURROUNDED;
            end else if (f && l) begin
                o_motor     = uoa_pkg::MOTOR_RIGHT;
                o_situation = uoa_pkg::SIT_FRONT_LEFT;
            end else if (f && r) begin
                o_motor     = uoa_pkg::MOTOR_LEFT;
                o_situation = uoa_pkg::SIT_FRONT_RIGHT;
            end else if (l) begin
                o_motor     = uoa_pkg::MOTOR_RIGHT;
                o_situation = uoa_pkg::SIT_LEFT;
            end else if (r) begin
                o_motor     = uoa_pkg::MOTOR_LEFT;
                o_situation = uoa_pkg::SIT_RIGHT;
            end else if (f) begin
                o_motor     = uoa_pkg::MOTOR_RIGHT;
                o_situation = uoa_pkg::SIT_FRONT;
            end else if (b) begin
                o_motor     = uoa_pkg::MOTOR_FORWARD;
                o_situation = uoa_pkg::SIT_BACK;
            end else begin
                o_motor     = uoa_pkg::MOTOR_FORWARD;
                o_situation = uoa_pkg::SIT_CLEAR;
            end
        end
    end

endmodule

### sv/ultrasonic_obstacle_avoider.sv
// Ultrasonic obstacle avoider, top level.
// Input stream: one beat per microsecond tick, tdata[3:0] = echo levels
// (bit0 front, bit1 left, bit2 right, bit3 back).
// Output stream: one beat per input beat, carrying the trigger level for
// that tick, the four averaged distances and, on the beat that closes a
// round of all four sensors, tlast with the motor command and situation.
// Configuration: plain write port, index 0..6, taken on any edge out of reset
// with the write enable high; index 7 is ignored.
// Path from input beat to output beat: input register, then result register.
// Throughput: one beat per cycle while the receiver does not stall; the tick
// update is a single pass of logic between the two registers.
// Reset clears the sequencer to the pre-trigger phase on the front sensor,
// zeroes the distance store and loads the register defaults.
// When the receiver stalls, the result register holds and the input
// register fills; tready drops only once both are occupied.
// Depends on uoa_pkg, uoa_cfg_regs, uoa_seq, uoa_decide.
module ultrasonic_obstacle_avoider #(
    parameter int READINGS_PER_SENSOR = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [3:0] echo_levels, [7:4] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] trigger_level, [2:1] motor_command, [5:3] situation, [12:6] front_cm,
    // [19:13] left_cm, [26:20] right_cm, [33:27] back_cm, [39:34] zero
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,   // decision_valid
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    uoa_pkg::t_cfg       cfg;
    uoa_pkg::t_seq_out   status;
    uoa_pkg::t_motor     motor;
    uoa_pkg::t_situation situation;

    logic                r_in_valid;
    logic [3:0]          r_in_echo;
    logic                r_out_valid;
    logic                r_out_trig;
    logic                r_out_last;
    uoa_pkg::t_motor     r_out_motor;
    uoa_pkg::t_situation r_out_sit;
    uoa_pkg::t_dist_arr  r_out_dist;
    logic                step;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    uoa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    uoa_seq #(
        .READINGS_PER_SENSOR (READINGS_PER_SENSOR)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_echo_levels (r_in_echo),
        .i_cfg         (cfg),
        .o_status      (status)
    );

    uoa_decide u_decide (
        .i_valid     (status.round_done),
        .i_dist      (status.dist_cm),
        .i_clearance (cfg.clearance),
        .o_motor     (motor),
        .o_situation (situation)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_echo <= i_s_axis_tdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_trig  <= status.trigger;
            r_out_last  <= status.round_done;
            r_out_motor <= motor;
            r_out_sit   <= situation;
            r_out_dist  <= status.dist_cm;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {6'd0, r_out_dist[3], r_out_dist[2], r_out_dist[1],
                              r_out_dist[0], r_out_sit, r_out_motor, r_out_trig};

endmodule

### sv/uoa_checker.sv
// Port-level checker for the obstacle avoider output stream, with its bind.
// Depends on ultrasonic_obstacle_avoider_assert.svh.
`include "ultrasonic_obstacle_avoider_assert.svh"

module uoa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata,
    input logic        i_m_tlast
);

    `UOA_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "output beat changed while stalled")

    // motor and situation are zero outside decision beats
    `UOA_ASSERT_IMP(a_no_decision_zero, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, i_m_tdata[5:1] == 5'd0, "decision fields set on a non-decision beat")

    // a round closes after the echo, never during the trigger pulse, and with a legal motor code
    `UOA_ASSERT_IMP(a_decision_shape, i_clk, i_rst_n, i_m_tvalid && i_m_tlast, !i_m_tdata[0] && (i_m_tdata[2:1] != 2'd3), "bad decision beat")

    `UOA_ASSERT_IMP(a_clear_forward, i_clk, i_rst_n, i_m_tvalid && i_m_tlast && (i_m_tdata[5:3] == 3'd6 || i_m_tdata[5:3] == 3'd7), i_m_tdata[2:1] == 2'd0, "clear path must drive forward")

endmodule

bind ultrasonic_obstacle_avoider uoa_checker u_uoa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);
